### rtl/core/tile_grid_rectangle_allocator_core_macros.svh
// assertion macros for the tile grid allocator core
`ifndef TILE_GRID_RECTANGLE_ALLOCATOR_CORE_MACROS_SVH
`define TILE_GRID_RECTANGLE_ALLOCATOR_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
// checked outside reset
`define TGRA_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("tgra assertion failed");
// checked at every edge, reset included
`define TGRA_ASSERT_NR(name, prop) \
  name: assert property (@(posedge clk_i) prop) \
    else $error("tgra assertion failed");
`else
`define TGRA_ASSERT(name, prop)
`define TGRA_ASSERT_NR(name, prop)
`endif

`endif

### rtl/core/tgra_pkg.sv
package tgra_pkg;

  // tile size register
  localparam int unsigned TSW = 11;
  localparam logic [TSW-1:0] TILE_SIZE_RESET = 11'd16;

  // payload widths
  localparam int unsigned PIXW   = 16;
  localparam int unsigned DIVW   = PIXW + 1;
  localparam int unsigned SLOTW  = 12;
  localparam int unsigned TILEW  = 6;
  localparam int unsigned EXTOW  = 7;
  localparam int unsigned COUNTW = 13;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_GROW,
    ST_ACC_RD,
    ST_ACC_OR,
    ST_TEST,
    ST_MARK_RD,
    ST_MARK_WR,
    ST_DONE
  } state_e;

endpackage

### rtl/core/tgra_ram.sv
module tgra_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/tile_grid_rectangle_allocator_core.sv
// channel   | handshake                      | payload
// ----------+--------------------------------+---------------------------------------------
// request   | start, busy (taken: start&!busy) | image_width_i, image_height_i
// result    | done_o (one-cycle strobe)      | slot_number_o, corner_*_o, extent_*_o, full_res_o
// config    | tile_size_we_i                 | tile_size_i
//
// per item: two 17-step divides on one shared divider, then growth steps, then for each scanned
//   row position a row fetch and up to nx - tw + 1 column tests, then marking and a posting
//   state; an oversized image posts after the divides
// the occupancy ram (one port each way) sets the row fetch and marking cost
// after reset a clearing pass over all MAX_TILES_Y rows zeroes the ram, busy stays high
// results cannot be stalled; the result registers free the core for the next item
`include "tile_grid_rectangle_allocator_core_macros.svh"

module tile_grid_rectangle_allocator_core import tgra_pkg::*; #(
  parameter int unsigned MAX_TILES_X = 64,
  parameter int unsigned MAX_TILES_Y = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // request
  input  logic              start,
  output logic              busy,
  input  logic [PIXW-1:0]   image_width_i,
  input  logic [PIXW-1:0]   image_height_i,
  // tile size register
  input  logic              tile_size_we_i,
  input  logic [TSW-1:0]    tile_size_i,
  // result
  output logic              done_o,
  output logic [SLOTW-1:0]  slot_number_o,
  output logic [TILEW-1:0]  corner_tile_x_o,
  output logic [TILEW-1:0]  corner_tile_y_o,
  output logic [PIXW-1:0]   corner_pixel_x_o,
  output logic [PIXW-1:0]   corner_pixel_y_o,
  output logic [EXTOW-1:0]  extent_tiles_x_o,
  output logic [EXTOW-1:0]  extent_tiles_y_o,
  output logic              full_res_o
);

  // index and extent widths
  localparam int unsigned CW  = $clog2(MAX_TILES_X);
  localparam int unsigned RW  = $clog2(MAX_TILES_Y);
  localparam int unsigned EXW = $clog2(MAX_TILES_X + 1);
  localparam int unsigned EYW = $clog2(MAX_TILES_Y + 1);
  localparam int unsigned EMW = (EXW > EYW) ? EXW : EYW;
  localparam int unsigned DCW = $clog2(DIVW);
  localparam int unsigned PXW = CW + TSW;
  localparam int unsigned PYW = RW + TSW;

  localparam logic [EXW-1:0]  MAX_X_E  = EXW'(MAX_TILES_X);
  localparam logic [EYW-1:0]  MAX_Y_E  = EYW'(MAX_TILES_Y);
  localparam logic [DIVW-1:0] MAX_X_D  = DIVW'(MAX_TILES_X);
  localparam logic [DIVW-1:0] MAX_Y_D  = DIVW'(MAX_TILES_Y);
  localparam logic [DCW-1:0]  DIV_LAST = DCW'(DIVW - 1);
  localparam logic [RW-1:0]   ROW_LAST = RW'(MAX_TILES_Y - 1);

  // doubling clamped at the grid limit
  function automatic logic [EXW-1:0] grow_x(input logic [EXW-1:0] e);
    logic [EXW:0] d;
    d = {e, 1'b0};
    grow_x = (d > {1'b0, MAX_X_E}) ? MAX_X_E : d[EXW-1:0];
  endfunction

  function automatic logic [EYW-1:0] grow_y(input logic [EYW-1:0] e);
    logic [EYW:0] d;
    d = {e, 1'b0};
    grow_y = (d > {1'b0, MAX_Y_E}) ? MAX_Y_E : d[EYW-1:0];
  endfunction

  // ------------------------------------------------------------------
  // registers
  // ------------------------------------------------------------------
  state_e              state_q, state_d;
  logic [TSW-1:0]      tile_size_q;
  logic [EXW-1:0]      ext_x_q, ext_x_d;
  logic [EYW-1:0]      ext_y_q, ext_y_d;
  logic [COUNTW-1:0]   placed_q, placed_d;
  logic [RW-1:0]       y_q, y_d;        // scan row, also the clear pointer
  logic                done_q, done_d;

  logic [PIXW-1:0]     h_q, h_d;
  logic [TSW-1:0]      rem_q, rem_d;
  logic [DIVW-1:0]     dq_q, dq_d;
  logic [DCW-1:0]      dcnt_q, dcnt_d;
  logic                dsel_q, dsel_d;  // 0: width divide, 1: height divide
  logic                too_big_q, too_big_d;
  logic [EXW-1:0]      tw_q, tw_d;
  logic [EYW-1:0]      th_q, th_d;
  logic [EXW-1:0]      nx_q, nx_d;
  logic [EYW-1:0]      ny_q, ny_d;
  logic [CW-1:0]       x_q, x_d;
  logic [EYW-1:0]      dy_q, dy_d;
  logic [MAX_TILES_X-1:0] acc_q, acc_d;     // or of the rows under the candidate
  logic [MAX_TILES_X-1:0] wmask_q, wmask_d; // tw ones from bit 0
  logic                full_q, full_d;

  // result registers
  logic [SLOTW-1:0]    slot_q, slot_d;
  logic [TILEW-1:0]    ctx_q, ctx_d, cty_q, cty_d;
  logic [PIXW-1:0]     cpx_q, cpx_d, cpy_q, cpy_d;
  logic [EXTOW-1:0]    eox_q, eox_d, eoy_q, eoy_d;
  logic                fres_q, fres_d;

  // ram port
  logic                   ram_we;
  logic [RW-1:0]          ram_waddr;
  logic [MAX_TILES_X-1:0] ram_wdata;
  logic [RW-1:0]          ram_raddr;
  logic [MAX_TILES_X-1:0] ram_rdata;

  // ------------------------------------------------------------------
  // shared units
  // ------------------------------------------------------------------
  logic [TSW-1:0]  ts_eff;
  logic [DIVW-1:0] div_w, div_h;
  logic [TSW:0]    trial;
  logic            ge;
  logic [TSW-1:0]  rem_step;
  logic [DIVW-1:0] q_step;
  logic            big;
  logic [MAX_TILES_X-1:0] shmask;
  logic            hit;
  logic            x_end, y_end, can_grow;
  logic [EYW-1:0]  row_sum;
  logic [RW-1:0]   row_addr;
  logic [PXW-1:0]  prod_x;
  logic [PYW-1:0]  prod_y;
  logic [MAX_TILES_X-1:0] wmask_new;

  // zero tile size behaves as one
  assign ts_eff = (tile_size_q == '0) ? TSW'(1) : tile_size_q;

  // ceiling divide dividends
  assign div_w = DIVW'(image_width_i) + DIVW'(ts_eff) - DIVW'(1);
  assign div_h = DIVW'(h_q) + DIVW'(ts_eff) - DIVW'(1);

  // restoring divider, one quotient bit a cycle
  assign trial    = {rem_q, dq_q[DIVW-1]};
  assign ge       = (trial >= {1'b0, ts_eff});
  assign rem_step = ge ? TSW'(trial - {1'b0, ts_eff}) : trial[TSW-1:0];
  assign q_step   = {dq_q[DIVW-2:0], ge};
  assign big      = dsel_q ? (q_step > MAX_Y_D) : (q_step > MAX_X_D);

  // rectangle mask at the candidate column, used for test and mark
  assign shmask = wmask_q << x_q;
  assign hit    = ((acc_q & shmask) == '0);

  assign x_end    = (EXW'(x_q) == (nx_q - tw_q));
  assign y_end    = (EYW'(y_q) == (ny_q - th_q));
  assign can_grow = !((nx_q == MAX_X_E) && (ny_q == MAX_Y_E));

  assign row_sum  = EYW'(y_q) + dy_q;
  assign row_addr = RW'(row_sum);

  assign prod_x = PXW'(x_q) * PXW'(ts_eff);
  assign prod_y = PYW'(y_q) * PYW'(ts_eff);

  always_comb begin
    for (int i = 0; i < MAX_TILES_X; i++) begin
      wmask_new[i] = (EXW'(i) < tw_q);
    end
  end

  // ------------------------------------------------------------------
  // next state
  // ------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (y_q == ROW_LAST) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) state_d = ST_DIV;
      end
      ST_DIV: begin
        if (dcnt_q == DIV_LAST && dsel_q) begin
          state_d = (too_big_q || big) ? ST_DONE : ST_GROW;
        end
      end
      ST_GROW: begin
        if (!(tw_q > nx_q) && !(th_q > ny_q)) state_d = ST_ACC_RD;
      end
      ST_ACC_RD: begin
        state_d = (dy_q == th_q) ? ST_TEST : ST_ACC_OR;
      end
      ST_ACC_OR: begin
        state_d = ST_ACC_RD;
      end
      ST_TEST: begin
        if (hit) begin
          state_d = ST_MARK_RD;
        end else if (x_end && y_end && !can_grow) begin
          state_d = ST_DONE;
        end else if (x_end) begin
          state_d = ST_ACC_RD;
        end
      end
      ST_MARK_RD: begin
        state_d = (dy_q == th_q) ? ST_DONE : ST_MARK_WR;
      end
      ST_MARK_WR: begin
        state_d = ST_MARK_RD;
      end
      ST_DONE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // ------------------------------------------------------------------
  // datapath and ram control
  // ------------------------------------------------------------------
  always_comb begin
    ext_x_d   = ext_x_q;
    ext_y_d   = ext_y_q;
    placed_d  = placed_q;
    y_d       = y_q;
    done_d    = 1'b0;
    h_d       = h_q;
    rem_d     = rem_q;
    dq_d      = dq_q;
    dcnt_d    = dcnt_q;
    dsel_d    = dsel_q;
    too_big_d = too_big_q;
    tw_d      = tw_q;
    th_d      = th_q;
    nx_d      = nx_q;
    ny_d      = ny_q;
    x_d       = x_q;
    dy_d      = dy_q;
    acc_d     = acc_q;
    wmask_d   = wmask_q;
    full_d    = full_q;
    slot_d    = slot_q;
    ctx_d     = ctx_q;
    cty_d     = cty_q;
    cpx_d     = cpx_q;
    cpy_d     = cpy_q;
    eox_d     = eox_q;
    eoy_d     = eoy_q;
    fres_d    = fres_q;
    ram_we    = 1'b0;
    ram_waddr = row_addr;
    ram_wdata = ram_rdata | shmask;
    ram_raddr = row_addr;

    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = y_q;
        ram_wdata = '0;
        y_d       = (y_q == ROW_LAST) ? '0 : y_q + RW'(1);
      end
      ST_IDLE: begin
        if (start) begin
          dq_d      = div_w;
          rem_d     = '0;
          dcnt_d    = '0;
          dsel_d    = 1'b0;
          too_big_d = 1'b0;
          full_d    = 1'b0;
          h_d       = image_height_i;
        end
      end
      ST_DIV: begin
        rem_d  = rem_step;
        dq_d   = q_step;
        dcnt_d = dcnt_q + DCW'(1);
        if (dcnt_q == DIV_LAST) begin
          dcnt_d    = '0;
          too_big_d = too_big_q | big;
          if (!dsel_q) begin
            tw_d   = EXW'(q_step);
            dsel_d = 1'b1;
            dq_d   = div_h;
            rem_d  = '0;
          end else begin
            th_d   = EYW'(q_step);
            nx_d   = ext_x_q;
            ny_d   = ext_y_q;
            full_d = too_big_q | big;
          end
        end
      end
      ST_GROW: begin
        wmask_d = wmask_new;
        if (tw_q > nx_q) begin
          nx_d = grow_x(nx_q);
        end else if (th_q > ny_q) begin
          ny_d = grow_y(ny_q);
        end else begin
          y_d   = '0;
          dy_d  = '0;
          acc_d = '0;
        end
      end
      ST_ACC_RD: begin
        if (dy_q == th_q) x_d = '0;
      end
      ST_ACC_OR: begin
        acc_d = acc_q | ram_rdata;
        dy_d  = dy_q + EYW'(1);
      end
      ST_TEST: begin
        if (hit) begin
          dy_d = '0;
        end else if (x_end) begin
          dy_d  = '0;
          acc_d = '0;
          if (!y_end) begin
            y_d = y_q + RW'(1);
          end else if (can_grow) begin
            // wider than tall grows down first, otherwise across
            y_d = '0;
            if (EMW'(nx_q) > EMW'(ny_q)) begin
              if (ny_q < MAX_Y_E) ny_d = grow_y(ny_q);
              else                nx_d = grow_x(nx_q);
            end else begin
              if (nx_q < MAX_X_E) nx_d = grow_x(nx_q);
              else                ny_d = grow_y(ny_q);
            end
          end else begin
            full_d = 1'b1;
          end
        end else begin
          x_d = x_q + CW'(1);
        end
      end
      ST_MARK_RD: begin
      end
      ST_MARK_WR: begin
        ram_we = 1'b1;
        dy_d   = dy_q + EYW'(1);
      end
      ST_DONE: begin
        done_d = 1'b1;
        fres_d = full_q;
        if (full_q) begin
          slot_d = '0;
          ctx_d  = '0;
          cty_d  = '0;
          cpx_d  = '0;
          cpy_d  = '0;
          eox_d  = EXTOW'(ext_x_q);
          eoy_d  = EXTOW'(ext_y_q);
        end else begin
          slot_d   = placed_q[SLOTW-1:0];
          ctx_d    = TILEW'(x_q);
          cty_d    = TILEW'(y_q);
          cpx_d    = PIXW'(prod_x);
          cpy_d    = PIXW'(prod_y);
          eox_d    = EXTOW'(nx_q);
          eoy_d    = EXTOW'(ny_q);
          ext_x_d  = nx_q;
          ext_y_d  = ny_q;
          placed_d = placed_q + COUNTW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // ------------------------------------------------------------------
  // storage
  // ------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      tile_size_q <= TILE_SIZE_RESET;
      ext_x_q     <= EXW'(1);
      ext_y_q     <= EYW'(1);
      placed_q    <= '0;
      y_q         <= '0;
      done_q      <= 1'b0;
    end else begin
      state_q  <= state_d;
      ext_x_q  <= ext_x_d;
      ext_y_q  <= ext_y_d;
      placed_q <= placed_d;
      y_q      <= y_d;
      done_q   <= done_d;
      if (tile_size_we_i) begin
        tile_size_q <= tile_size_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    h_q       <= h_d;
    rem_q     <= rem_d;
    dq_q      <= dq_d;
    dcnt_q    <= dcnt_d;
    dsel_q    <= dsel_d;
    too_big_q <= too_big_d;
    tw_q      <= tw_d;
    th_q      <= th_d;
    nx_q      <= nx_d;
    ny_q      <= ny_d;
    x_q       <= x_d;
    dy_q      <= dy_d;
    acc_q     <= acc_d;
    wmask_q   <= wmask_d;
    full_q    <= full_d;
    slot_q    <= slot_d;
    ctx_q     <= ctx_d;
    cty_q     <= cty_d;
    cpx_q     <= cpx_d;
    cpy_q     <= cpy_d;
    eox_q     <= eox_d;
    eoy_q     <= eoy_d;
    fres_q    <= fres_d;
  end

  // one row of the occupancy bitmap per entry, full row stride
  tgra_ram #(
    .WIDTH (MAX_TILES_X),
    .DEPTH (MAX_TILES_Y)
  ) u_occ_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // ------------------------------------------------------------------
  // outputs
  // ------------------------------------------------------------------
  assign busy             = (state_q != ST_IDLE);
  assign done_o           = done_q;
  assign slot_number_o    = slot_q;
  assign corner_tile_x_o  = ctx_q;
  assign corner_tile_y_o  = cty_q;
  assign corner_pixel_x_o = cpx_q;
  assign corner_pixel_y_o = cpy_q;
  assign extent_tiles_x_o = eox_q;
  assign extent_tiles_y_o = eoy_q;
  assign full_res_o       = fres_q;

  // ------------------------------------------------------------------
  // assertions
  // ------------------------------------------------------------------
  `TGRA_ASSERT_NR(a_busy_after_accept, (start && !busy) |=> busy)
  `TGRA_ASSERT(a_done_from_busy, done_o |-> $past(busy))
  `TGRA_ASSERT(a_extent_no_shrink, 1'b1 |=> ((ext_x_q >= $past(ext_x_q)) && (ext_y_q >= $past(ext_y_q))))
  `TGRA_ASSERT(a_full_no_corner, (done_o && full_res_o) |-> ((slot_number_o == '0) && (corner_tile_x_o == '0) && (corner_tile_y_o == '0)))

endmodule
